// ===== rtl/fcvn_pkg.sv =====
// Shared types, codes and helpers for the fast-charge voltage negotiator.
package fcvn_pkg;

  localparam int unsigned WaitWidth = 16;

  // Reset values of the timing registers, in one-millisecond ticks.
  localparam logic [WaitWidth-1:0] StartCheckMsReset = 16'd10;
  localparam logic [WaitWidth-1:0] HandshakeMsReset  = 16'd1500;
  localparam logic [WaitWidth-1:0] NewModeMsReset    = 16'd100;

  // Announced voltages in tenths of a volt.
  localparam logic [7:0] Volt5V  = 8'd50;
  localparam logic [7:0] Volt9V  = 8'd90;
  localparam logic [7:0] Volt12V = 8'd120;
  localparam logic [7:0] Volt20V = 8'd200;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_START    = 2'd1,
    OP_SET_MODE = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_START_CHECK = 2'd0,
    REG_HANDSHAKE   = 2'd1,
    REG_NEW_MODE    = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    STEP_IDLE      = 4'd0,
    STEP_CHECK1    = 4'd1,
    STEP_HANDSHAKE = 4'd2,
    STEP_CHECK2    = 4'd3,
    STEP_EXIT_CONT = 4'd4,
    STEP_MODE_WAIT = 4'd5
  } step_t;

  localparam logic [1:0] LVL_GND = 2'd0;
  localparam logic [1:0] LVL_06  = 2'd1;
  localparam logic [1:0] LVL_33  = 2'd2;

  localparam logic [2:0] MODE_5V   = 3'd0;
  localparam logic [2:0] MODE_9V   = 3'd1;
  localparam logic [2:0] MODE_12V  = 3'd2;
  localparam logic [2:0] MODE_20V  = 3'd3;
  localparam logic [2:0] MODE_CONT = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_SUPP = 2'd1;
  localparam logic [1:0] ST_LIMITED  = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  typedef struct packed {
    logic [WaitWidth-1:0] start_check_ms;
    logic [WaitWidth-1:0] handshake_ms;
    logic [WaitWidth-1:0] new_mode_ms;
  } cfg_t;

  typedef struct packed {
    step_t                step;
    logic [WaitWidth-1:0] wait_cnt;
    logic [2:0]           rec_mode;
    logic [2:0]           pend_mode;
    logic [7:0]           volt;
    logic [1:0]           dp_drive;
    logic [1:0]           dm_drive;
    logic                 dm_out;
    logic [1:0]           last_status;
  } state_t;

  typedef struct packed {
    logic [1:0] dp_level;
    logic [1:0] dm_level;
    logic       dm_drive_enable;
    logic [2:0] current_mode;
    logic [7:0] voltage_tenths;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [1:0] dp;
    logic [1:0] dm;
    logic [7:0] volt;
  } levels_t;

  // Line levels and announced voltage for a mode; continuous mode keeps the voltage.
  function automatic levels_t mode_levels(input logic [2:0] mode, input logic [7:0] volt);
    levels_t lv;
    case (mode)
      MODE_5V:  lv = '{dp: LVL_06, dm: LVL_GND, volt: Volt5V};
      MODE_9V:  lv = '{dp: LVL_33, dm: LVL_06,  volt: Volt9V};
      MODE_12V: lv = '{dp: LVL_06, dm: LVL_06,  volt: Volt12V};
      MODE_20V: lv = '{dp: LVL_33, dm: LVL_33,  volt: Volt20V};
      default:  lv = '{dp: LVL_06, dm: LVL_33,  volt: volt};
    endcase
    return lv;
  endfunction

endpackage

// ===== rtl/fcvn_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
interface fcvn_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [2:0] requested_mode;
  logic       dm_sense;

  modport source (output valid, output opcode, output requested_mode, output dm_sense,
                  input ready);
  modport sink (input valid, input opcode, input requested_mode, input dm_sense,
                output ready);
endinterface

interface fcvn_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] dp_level;
  logic [1:0] dm_level;
  logic       dm_drive_enable;
  logic [2:0] current_mode;
  logic [7:0] voltage_tenths;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, output dp_level, output dm_level, output dm_drive_enable,
                  output current_mode, output voltage_tenths, output busy_res,
                  output done_res, output status, input ready);
  modport sink (input valid, input dp_level, input dm_level, input dm_drive_enable,
                input current_mode, input voltage_tenths, input busy_res,
                input done_res, input status, output ready);
endinterface

// ===== rtl/fcvn_step.sv =====
// Sequencer update: next negotiation state and the result for one command beat.
module fcvn_step import fcvn_pkg::*; (
  input  state_t     cur,
  input  cfg_t       cfg,
  input  logic [1:0] opcode,
  input  logic [2:0] req_mode,
  input  logic       dm_sense,
  output state_t     nxt,
  output result_t    res
);

  logic                 busy;
  logic                 is_tick;
  logic                 expire;
  logic                 mode_ok;
  logic                 leave_cont;
  logic [WaitWidth-1:0] wait_dec;
  levels_t              req_lv;
  levels_t              pend_lv;
  step_t                step_nxt;
  logic                 done;
  logic                 reject;

  // Shared decode of the beat against the current step.
  assign busy       = (cur.step != STEP_IDLE);
  assign is_tick    = (opcode == OP_TICK);
  assign wait_dec   = (cur.wait_cnt != '0) ? cur.wait_cnt - 1'b1 : cur.wait_cnt;
  assign expire     = busy && is_tick && (wait_dec == '0);
  assign mode_ok    = !(req_mode > MODE_CONT);
  assign leave_cont = (cur.rec_mode == MODE_CONT) && (req_mode != MODE_CONT);
  assign req_lv     = mode_levels(req_mode, cur.volt);
  assign pend_lv    = mode_levels(cur.pend_mode, cur.volt);

  // Next step of the sequencer.
  always_comb begin
    step_nxt = cur.step;
    case (opcode)
      OP_TICK: begin
        if (expire) begin
          case (cur.step)
            STEP_CHECK1:    step_nxt = dm_sense ? STEP_HANDSHAKE : STEP_IDLE;
            STEP_HANDSHAKE: step_nxt = STEP_CHECK2;
            STEP_EXIT_CONT: step_nxt = (cur.pend_mode == MODE_5V) ? STEP_IDLE : STEP_MODE_WAIT;
            default:        step_nxt = STEP_IDLE;
          endcase
        end
      end
      OP_START: begin
        if (!busy) step_nxt = STEP_CHECK1;
      end
      OP_SET_MODE: begin
        if (!busy && mode_ok) step_nxt = leave_cont ? STEP_EXIT_CONT : STEP_MODE_WAIT;
      end
      default: step_nxt = cur.step;
    endcase
  end

  // Line levels, timers, recorded mode and status for the beat.
  always_comb begin
    nxt      = cur;
    nxt.step = step_nxt;
    done     = 1'b0;
    reject   = 1'b0;
    case (opcode)
      OP_TICK: begin
        if (busy) nxt.wait_cnt = wait_dec;
        if (expire) begin
          case (cur.step)
            STEP_CHECK1: begin
              if (!dm_sense) begin
                nxt.last_status = ST_NOT_SUPP;
                nxt.wait_cnt    = '0;
                done            = 1'b1;
              end else begin
                nxt.rec_mode = MODE_5V;
                nxt.volt     = Volt5V;
                nxt.dp_drive = LVL_06;
                nxt.wait_cnt = cfg.handshake_ms;
              end
            end
            STEP_HANDSHAKE: begin
              nxt.dp_drive = LVL_33;
              nxt.wait_cnt = cfg.start_check_ms;
            end
            STEP_CHECK2: begin
              nxt.wait_cnt = '0;
              done         = 1'b1;
              if (dm_sense) begin
                nxt.last_status = ST_LIMITED;
              end else begin
                nxt.last_status = ST_OK;
                nxt.dm_out      = 1'b1;
              end
            end
            STEP_EXIT_CONT: begin
              if (cur.pend_mode == MODE_5V) begin
                nxt.rec_mode    = MODE_5V;
                nxt.volt        = Volt5V;
                nxt.last_status = ST_OK;
                nxt.wait_cnt    = '0;
                done            = 1'b1;
              end else begin
                nxt.dp_drive = pend_lv.dp;
                nxt.dm_drive = pend_lv.dm;
                nxt.volt     = pend_lv.volt;
                nxt.rec_mode = cur.pend_mode;
                nxt.wait_cnt = cfg.new_mode_ms;
              end
            end
            default: begin
              nxt.last_status = ST_OK;
              nxt.wait_cnt    = '0;
              done            = 1'b1;
            end
          endcase
        end
      end
      OP_START: begin
        if (busy) begin
          reject = 1'b1;
        end else begin
          nxt.dm_out   = 1'b0;
          nxt.dp_drive = LVL_33;
          nxt.wait_cnt = cfg.start_check_ms;
        end
      end
      OP_SET_MODE: begin
        if (busy || !mode_ok) begin
          reject = 1'b1;
        end else if (leave_cont) begin
          // Leaving continuous mode goes through 5 V levels first.
          nxt.dp_drive  = LVL_06;
          nxt.dm_drive  = LVL_GND;
          nxt.pend_mode = req_mode;
          nxt.wait_cnt  = cfg.new_mode_ms;
        end else begin
          nxt.dp_drive = req_lv.dp;
          nxt.dm_drive = req_lv.dm;
          nxt.volt     = req_lv.volt;
          nxt.rec_mode = req_mode;
          nxt.wait_cnt = cfg.new_mode_ms;
        end
      end
      default: nxt.wait_cnt = cur.wait_cnt;
    endcase
  end

  // Result fields reflect the state after this beat.
  always_comb begin
    res.dp_level        = nxt.dp_drive;
    res.dm_level        = nxt.dm_drive;
    res.dm_drive_enable = nxt.dm_out;
    res.current_mode    = nxt.rec_mode;
    res.voltage_tenths  = nxt.volt;
    res.busy_res        = (step_nxt != STEP_IDLE);
    res.done_res        = done;
    res.status          = reject ? ST_REJECTED : nxt.last_status;
  end

endmodule

// ===== rtl/fcvn_skid.sv =====
// Two-entry result buffer: output register plus a skid register.
module fcvn_skid import fcvn_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    main_v_r;
  logic    skid_v_r;
  result_t main_r;
  result_t skid_r;

  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  // Valid bits: the skid entry fills only while the output register is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ready || !main_v_r) begin
      main_v_r <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_ready || !main_v_r) begin
      main_r <= skid_v_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

// ===== rtl/fast_charge_voltage_negotiator.sv =====
// Top level of the sink-side fast-charge voltage negotiator.
//
// Usage: the in_ch channel takes one beat per millisecond tick or command
// (opcode tick, start handshake, set mode) together with the sensed D- level.
// Every accepted beat yields exactly one result beat on out_ch carrying the
// D+/D- drive levels, D- drive enable, recorded mode, announced voltage,
// busy and done flags, and status. Commands that arrive during a sequence
// are rejected with status 3 on that beat only.
// The sequencer state and the result are registered at the edge that accepts
// the beat. Throughput is one beat per cycle while in_ch.ready is high, set
// by the combinational sequencer update. A two-entry output buffer lets the
// block keep accepting while out_ch stalls; in_ch.ready drops only when both
// entries hold results, and rises again once out_ch takes one.
// The cfg port writes the three timing registers (start check, handshake,
// new mode wait) at any edge with cfg_we high; write them only while idle.
// Synchronous reset restores the idle step, 5 V mode, grounded lines and the
// default timings, and empties the output buffer.
module fast_charge_voltage_negotiator import fcvn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fcvn_in_if.sink              in_ch,
  fcvn_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [WaitWidth-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t step_res;
  result_t out_res;
  logic    in_fire;
  logic    buf_ready;

  assign in_ch.ready = buf_ready;
  assign in_fire     = in_ch.valid && buf_ready;

  // Timing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_check_ms <= StartCheckMsReset;
      cfg_r.handshake_ms   <= HandshakeMsReset;
      cfg_r.new_mode_ms    <= NewModeMsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_CHECK: cfg_r.start_check_ms <= cfg_wdata;
        REG_HANDSHAKE:   cfg_r.handshake_ms   <= cfg_wdata;
        REG_NEW_MODE:    cfg_r.new_mode_ms    <= cfg_wdata;
        default:         cfg_r                <= cfg_r;
      endcase
    end
  end

  fcvn_step u_step (
    .cur      (state_r),
    .cfg      (cfg_r),
    .opcode   (in_ch.opcode),
    .req_mode (in_ch.requested_mode),
    .dm_sense (in_ch.dm_sense),
    .nxt      (state_nxt),
    .res      (step_res)
  );

  // Sequencer state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{step: STEP_IDLE, wait_cnt: '0, rec_mode: MODE_5V, pend_mode: MODE_5V,
                   volt: Volt5V, dp_drive: LVL_GND, dm_drive: LVL_GND, dm_out: 1'b0,
                   last_status: ST_OK};
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  fcvn_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (step_res),
    .can_push  (buf_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  assign out_ch.dp_level        = out_res.dp_level;
  assign out_ch.dm_level        = out_res.dm_level;
  assign out_ch.dm_drive_enable = out_res.dm_drive_enable;
  assign out_ch.current_mode    = out_res.current_mode;
  assign out_ch.voltage_tenths  = out_res.voltage_tenths;
  assign out_ch.busy_res        = out_res.busy_res;
  assign out_ch.done_res        = out_res.done_res;
  assign out_ch.status          = out_res.status;

  // The wait counter is cleared whenever the sequencer is idle.
  a_idle_wait_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.step == STEP_IDLE) |-> (state_r.wait_cnt == '0))
    else $error("wait counter nonzero while idle");

  // A finishing beat never reports the sequence as still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.done_res) |-> !out_ch.busy_res)
    else $error("done and busy reported together");

  // Back-pressure only appears when a result is waiting at the output.
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with empty output");

  // A beat accepted into an empty buffer shows up at the output next cycle.
  a_latency_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !out_ch.valid) |=> out_ch.valid)
    else $error("result missing one cycle after accept");

endmodule

// ===== verif/fcvn_result_checker.sv =====
// Result checker for the fast-charge voltage negotiator: line-state predictor and beat compare.
`timescale 1ns / 1ps

module fcvn_result_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  fcvn_in_if                            cmd_ch,
  fcvn_out_if                           res_ch,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [fcvn_pkg::WaitWidth-1:0] cfg_wdata,
  output int unsigned                   mismatch_count,
  output int unsigned                   outstanding,
  output int unsigned                   results_checked,
  output int unsigned                   sequences_done
);
  import fcvn_pkg::*;

  localparam int unsigned PrintCap = 40;

  // Timing registers as the block should hold them.
  logic [WaitWidth-1:0] t_start_check;
  logic [WaitWidth-1:0] t_handshake;
  logic [WaitWidth-1:0] t_new_mode;

  // Predicted sequencer and line state.
  step_t                seq_step;
  logic [WaitWidth-1:0] wait_left;
  logic [2:0]           mode_now;
  logic [2:0]           mode_target;
  logic [7:0]           volt_now;
  logic [1:0]           dp_now;
  logic [1:0]           dm_now;
  logic                 dm_driven;
  logic [1:0]           last_st;

  result_t predicted_line_states[$];
  result_t next_line;

  int unsigned fail_tally   = 0;
  int unsigned checked_tally = 0;
  int unsigned done_tally   = 0;

  task automatic restore_reset_state();
    t_start_check = StartCheckMsReset;
    t_handshake   = HandshakeMsReset;
    t_new_mode    = NewModeMsReset;
    seq_step      = STEP_IDLE;
    wait_left     = '0;
    mode_now      = MODE_5V;
    mode_target   = MODE_5V;
    volt_now      = Volt5V;
    dp_now        = LVL_GND;
    dm_now        = LVL_GND;
    dm_driven     = 1'b0;
    last_st       = ST_OK;
    predicted_line_states.delete();
  endtask

  // Drive the line pattern of a mode and start the settle wait.
  task automatic apply_mode(input logic [2:0] m);
    case (m)
      MODE_5V: begin
        dp_now = LVL_06; dm_now = LVL_GND; volt_now = Volt5V;
      end
      MODE_9V: begin
        dp_now = LVL_33; dm_now = LVL_06; volt_now = Volt9V;
      end
      MODE_12V: begin
        dp_now = LVL_06; dm_now = LVL_06; volt_now = Volt12V;
      end
      MODE_20V: begin
        dp_now = LVL_33; dm_now = LVL_33; volt_now = Volt20V;
      end
      default: begin
        // Continuous mode keeps the announced voltage.
        dp_now = LVL_06; dm_now = LVL_33;
      end
    endcase
    mode_now  = m;
    wait_left = t_new_mode;
    seq_step  = STEP_MODE_WAIT;
  endtask

  task automatic end_sequence(input logic [1:0] st);
    last_st   = st;
    seq_step  = STEP_IDLE;
    wait_left = '0;
  endtask

  // Advance the predicted sequencer by one command beat and build its result.
  task automatic advance_negotiation(input logic [1:0] op, input logic [2:0] req,
                                     input logic sense, output result_t r);
    logic finished;
    logic refused;
    logic was_busy;
    finished = 1'b0;
    refused  = 1'b0;
    was_busy = (seq_step != STEP_IDLE);
    case (op)
      OP_TICK: begin
        if (was_busy) begin
          // A zero wait ends on the first tick, the same as a wait of one.
          if (wait_left != 0) wait_left = wait_left - 1'b1;
          if (wait_left == 0) begin
            case (seq_step)
              STEP_CHECK1: begin
                if (!sense) begin
                  end_sequence(ST_NOT_SUPP);
                  finished = 1'b1;
                end else begin
                  mode_now  = MODE_5V;
                  volt_now  = Volt5V;
                  dp_now    = LVL_06;
                  wait_left = t_handshake;
                  seq_step  = STEP_HANDSHAKE;
                end
              end
              STEP_HANDSHAKE: begin
                dp_now    = LVL_33;
                wait_left = t_start_check;
                seq_step  = STEP_CHECK2;
              end
              STEP_CHECK2: begin
                if (sense) begin
                  end_sequence(ST_LIMITED);
                end else begin
                  dm_driven = 1'b1;
                  end_sequence(ST_OK);
                end
                finished = 1'b1;
              end
              STEP_EXIT_CONT: begin
                // Leaving continuous mode rests at 5 V; a 5 V target ends here.
                if (mode_target == MODE_5V) begin
                  mode_now = MODE_5V;
                  volt_now = Volt5V;
                  end_sequence(ST_OK);
                  finished = 1'b1;
                end else begin
                  apply_mode(mode_target);
                end
              end
              default: begin
                end_sequence(ST_OK);
                finished = 1'b1;
              end
            endcase
          end
        end
      end
      OP_START: begin
        if (was_busy) begin
          refused = 1'b1;
        end else begin
          dm_driven = 1'b0;
          dp_now    = LVL_33;
          wait_left = t_start_check;
          seq_step  = STEP_CHECK1;
        end
      end
      OP_SET_MODE: begin
        if (was_busy || req > MODE_CONT) begin
          refused = 1'b1;
        end else if (mode_now == MODE_CONT && req != MODE_CONT) begin
          dp_now      = LVL_06;
          dm_now      = LVL_GND;
          mode_target = req;
          wait_left   = t_new_mode;
          seq_step    = STEP_EXIT_CONT;
        end else begin
          apply_mode(req);
        end
      end
      default: begin
        // The unused opcode changes nothing, not even the wait.
      end
    endcase
    r.dp_level        = dp_now;
    r.dm_level        = dm_now;
    r.dm_drive_enable = dm_driven;
    r.current_mode    = mode_now;
    r.voltage_tenths  = volt_now;
    r.busy_res        = (seq_step != STEP_IDLE);
    r.done_res        = finished;
    r.status          = refused ? ST_REJECTED : last_st;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (fail_tally < PrintCap)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_tally++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Compare one result beat against the oldest prediction.
  task automatic compare_result();
    result_t want;
    if (predicted_line_states.size() == 0) begin
      report_mismatch("result beat with nothing pending (status)", 8'(res_ch.status),
                      8'(ST_OK));
    end else begin
      want = predicted_line_states.pop_front();
      check_field("dp_level", 8'(res_ch.dp_level), 8'(want.dp_level));
      check_field("dm_level", 8'(res_ch.dm_level), 8'(want.dm_level));
      check_field("dm_drive_enable", 8'(res_ch.dm_drive_enable), 8'(want.dm_drive_enable));
      check_field("current_mode", 8'(res_ch.current_mode), 8'(want.current_mode));
      check_field("voltage_tenths", res_ch.voltage_tenths, want.voltage_tenths);
      check_field("busy_res", 8'(res_ch.busy_res), 8'(want.busy_res));
      check_field("done_res", 8'(res_ch.done_res), 8'(want.done_res));
      check_field("status", 8'(res_ch.status), 8'(want.status));
      checked_tally++;
      if (want.done_res) done_tally++;
    end
  endtask

  // Result beats are compared before the same edge's command beat is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      restore_reset_state();
    end else begin
      if (res_ch.valid && res_ch.ready) compare_result();
      if (cmd_ch.valid && cmd_ch.ready) begin
        advance_negotiation(cmd_ch.opcode, cmd_ch.requested_mode, cmd_ch.dm_sense, next_line);
        predicted_line_states.push_back(next_line);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_START_CHECK: t_start_check = cfg_wdata;
          REG_HANDSHAKE:   t_handshake   = cfg_wdata;
          REG_NEW_MODE:    t_new_mode    = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatch_count  <= fail_tally;
    outstanding     <= predicted_line_states.size();
    results_checked <= checked_tally;
    sequences_done  <= done_tally;
  end

endmodule

// ===== verif/tb_fast_charge_voltage_negotiator.sv =====
// Testbench top for the fast-charge voltage negotiator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_fast_charge_voltage_negotiator;
  import fcvn_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned PhaseBeats = 290;
  localparam int unsigned TxIdlePct[3] = '{14, 86, 0};
  localparam int unsigned RxIdlePct[3] = '{86, 14, 0};

  // Sense selection for runs of ticks.
  localparam int SENSE_LOW  = 0;
  localparam int SENSE_HIGH = 1;
  localparam int SENSE_RAND = 2;

  // Requested modes outside the legal range.
  localparam logic [2:0] MODE_BAD_LO = 3'd5;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;

  localparam logic [WaitWidth-1:0] WaitLong = 16'd24;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [WaitWidth-1:0] cfg_wdata;

  fcvn_in_if  cmd_ch();
  fcvn_out_if res_ch();

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned sequences_done;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned beats_sent = 0;
  int unsigned quiet_cycles = 0;

  // Timing values last written, used to size tick runs.
  logic [WaitWidth-1:0] sc_ms = StartCheckMsReset;
  logic [WaitWidth-1:0] hs_ms = HandshakeMsReset;
  logic [WaitWidth-1:0] nm_ms = NewModeMsReset;

  fast_charge_voltage_negotiator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_ch),
    .out_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  fcvn_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_ch         (cmd_ch),
    .res_ch         (res_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .results_checked(results_checked),
    .sequences_done (sequences_done)
  );

  always #5 clk = ~clk;

  // Result side stalls at the rate of the current phase.
  initial res_ch.ready = 1'b0;
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Watchdog: no beat moved for %0d cycles, %0d results outstanding",
               StallLimit, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  // A wait of zero lasts one tick.
  function automatic int wait_len(input logic [WaitWidth-1:0] ms);
    return (ms == 0) ? 1 : int'(ms);
  endfunction

  // Ticks that bring any sequence under the current timing back to idle.
  function automatic int idle_bound();
    int start_len;
    int mode_len;
    start_len = 2 * wait_len(sc_ms) + wait_len(hs_ms);
    mode_len  = 2 * wait_len(nm_ms);
    return (start_len > mode_len) ? start_len : mode_len;
  endfunction

  // Offer one command beat, with random idle cycles ahead of it.
  task automatic send_beat(input opcode_t op, input logic [2:0] req, input logic sense);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.opcode         <= op;
    cmd_ch.requested_mode <= req;
    cmd_ch.dm_sense       <= sense;
    do @(posedge clk); while (!cmd_ch.ready);
    if (op != OP_UNUSED) beats_sent++;
  endtask

  task automatic send_ticks(input int n, input int sense_sel);
    repeat (n) begin
      send_beat(OP_TICK, 3'($urandom),
                (sense_sel == SENSE_RAND) ? 1'($urandom) : (sense_sel == SENSE_HIGH));
    end
  endtask

  task automatic stray_command();
    send_beat(opcode_t'($urandom_range(0, 3)), 3'($urandom), 1'($urandom));
  endtask

  // Hold off the sender until every predicted result has been seen.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write all three timing registers; the block must be idle.
  task automatic program_timing(input logic [WaitWidth-1:0] sc, input logic [WaitWidth-1:0] hs,
                                input logic [WaitWidth-1:0] nm);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_CHECK;
    cfg_wdata <= sc;
    @(posedge clk);
    cfg_index <= REG_HANDSHAKE;
    cfg_wdata <= hs;
    @(posedge clk);
    cfg_index <= REG_NEW_MODE;
    cfg_wdata <= nm;
    @(posedge clk);
    cfg_we <= 1'b0;
    sc_ms = sc;
    hs_ms = hs;
    nm_ms = nm;
  endtask

  // One random session: mostly complete sequences with random content, some noise.
  task automatic random_session();
    int pick;
    bit tidy;
    pick = $urandom_range(0, 99);
    tidy = ($urandom_range(0, 99) < 75);
    if (pick < 45) begin
      send_beat(OP_START, 3'($urandom), 1'($urandom));
      send_ticks(wait_len(sc_ms), tidy ? SENSE_HIGH : SENSE_RAND);
      if ($urandom_range(0, 9) == 0) stray_command();
      send_ticks(wait_len(hs_ms), SENSE_RAND);
      send_ticks(wait_len(sc_ms), tidy ? SENSE_LOW : SENSE_RAND);
    end else if (pick < 85) begin
      send_beat(OP_SET_MODE,
                ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                             : 3'($urandom_range(5, 7)),
                1'($urandom));
      if ($urandom_range(0, 9) == 0) stray_command();
      send_ticks(tidy ? 2 * wait_len(nm_ms) : $urandom_range(0, 2 * wait_len(nm_ms)),
                 SENSE_RAND);
    end else begin
      repeat ($urandom_range(1, 4)) stray_command();
    end
    send_ticks($urandom_range(0, 2), SENSE_RAND);
    if ($urandom_range(0, 99) < 3) drain_results();
  endtask

  initial begin
    int phase_goal;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_START_CHECK;
    cfg_wdata             = '0;
    cmd_ch.valid          = 1'b0;
    cmd_ch.opcode         = OP_TICK;
    cmd_ch.requested_mode = MODE_5V;
    cmd_ch.dm_sense       = 1'b0;
    tx_idle_pct           = TxIdlePct[0];
    rx_idle_pct           = RxIdlePct[0];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Set mode before any start, under the reset timing.
    send_beat(OP_SET_MODE, MODE_12V, 1'b0);
    send_ticks(wait_len(NewModeMsReset), SENSE_RAND);

    // Directed beats with short waits, the start check wait at zero.
    program_timing(16'd0, 16'd1, 16'd2);
    send_beat(OP_UNUSED, MODE_BAD_HI, 1'b1);
    send_beat(OP_SET_MODE, MODE_BAD_LO, 1'b0);
    // Commands while a mode change is settling are refused.
    send_beat(OP_SET_MODE, MODE_9V, 1'b1);
    send_beat(OP_START, MODE_5V, 1'b1);
    send_beat(OP_SET_MODE, MODE_5V, 1'b0);
    send_ticks(2, SENSE_LOW);
    // Start with D- low at the first check: not supported.
    send_beat(OP_START, MODE_BAD_HI, 1'b0);
    send_ticks(1, SENSE_LOW);
    // Start with D- still high at the second check: limited support.
    send_beat(OP_START, MODE_5V, 1'b0);
    send_ticks(1, SENSE_HIGH);
    send_ticks(1, SENSE_LOW);
    send_ticks(1, SENSE_HIGH);
    // Full handshake ending with D- low, so D- becomes an output.
    send_beat(OP_START, MODE_CONT, 1'b1);
    send_ticks(1, SENSE_HIGH);
    send_ticks(1, SENSE_HIGH);
    send_ticks(1, SENSE_LOW);
    // Into continuous mode and back out to 5 V.
    send_beat(OP_SET_MODE, MODE_CONT, 1'b0);
    send_ticks(2, SENSE_RAND);
    send_beat(OP_SET_MODE, MODE_5V, 1'b1);
    send_ticks(2, SENSE_RAND);

    // Random phases, each with its own idle mix and timing.
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct <= TxIdlePct[ph];
      rx_idle_pct <= RxIdlePct[ph];
      send_ticks(idle_bound(), SENSE_RAND);
      program_timing(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                     16'($urandom_range(0, 6)));
      phase_goal = beats_sent + PhaseBeats;
      while (beats_sent < phase_goal) random_session();
    end

    // Long waits: one full handshake and one mode change with long timing.
    send_ticks(idle_bound(), SENSE_RAND);
    program_timing(WaitLong, WaitLong, WaitLong);
    send_beat(OP_START, MODE_5V, 1'b0);
    send_ticks(wait_len(WaitLong), SENSE_HIGH);
    send_ticks(wait_len(WaitLong), SENSE_RAND);
    send_ticks(wait_len(WaitLong), SENSE_LOW);
    send_beat(OP_SET_MODE, MODE_20V, 1'b1);
    send_ticks(wait_len(WaitLong), SENSE_RAND);

    drain_results();
    repeat (8) @(posedge clk);
    $display("Drove %0d command and tick beats across three idle mixes, timing 0 to %0d ms.",
             beats_sent, WaitLong);
    $display("Compared %0d result beats field by field; %0d sequences reached done.",
             results_checked, sequences_done);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
